// ===== hw/rtl/ltl_pkg.sv =====
package ltl_pkg;

    // Fixed-point scaling of the channel ratio and of the final result.
    localparam int RATIO_SCALE = 9;
    localparam int LUX_SCALE   = 14;

    // Field widths.
    localparam int CNT_W  = 16;
    localparam int LUX_W  = 12;
    localparam int LUX_MAX = 2496;

    // An unsaturated quotient ir*2^(RATIO_SCALE+1)/broad stays below 2^(RATIO_SCALE+2)
    // whenever ir < 2*broad; anything larger lies beyond the last breakpoint anyway.
    localparam int QUO_W = RATIO_SCALE + 2;

    localparam int COEF_W = 10;
    localparam int PROD_W = CNT_W + COEF_W;
    localparam int NUM_SEG = 8;

    typedef struct packed {
        logic [COEF_W-1:0] b;
        logic [COEF_W-1:0] m;
    } t_coef;

    // Breakpoints and slope pairs for the T package.
    localparam logic [QUO_W-1:0] SEG_K [NUM_SEG] = '{
        11'h040, 11'h080, 11'h0c0, 11'h100, 11'h138, 11'h19a, 11'h29a, 11'h29a
    };
    localparam logic [COEF_W-1:0] SEG_B [NUM_SEG] = '{
        10'h1f2, 10'h214, 10'h23f, 10'h270, 10'h16f, 10'h0d2, 10'h018, 10'h000
    };
    localparam logic [COEF_W-1:0] SEG_M [NUM_SEG] = '{
        10'h1be, 10'h2d1, 10'h37b, 10'h3fe, 10'h1fc, 10'h0fb, 10'h012, 10'h000
    };

    // The first breakpoint that the halved ratio does not exceed selects the pair.
    function automatic t_coef seg_coef(input logic [QUO_W-1:0] half);
        t_coef c;
        logic  hit;
        c   = '0;
        hit = 1'b0;
        for (int i = 0; i < NUM_SEG; i++) begin
            if (!hit && (half <= SEG_K[i])) begin
                c.b = SEG_B[i];
                c.m = SEG_M[i];
                hit = 1'b1;
            end
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/two_channel_light_to_lux.sv =====
// An accepted word passes the divider stages, then the segment, product and output registers, to its lux word.
// Throughput: one word per cycle while the output is not stalled; the eleven-stage restoring divider sets the depth.
// A stall at the output holds every stage; no word is dropped or repeated.
// Reset (i_rst_n, synchronous, active low) clears all stage valid bits only;
// no clearing pass is needed, so a word may enter in the first cycle after reset.
module two_channel_light_to_lux (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [ltl_pkg::CNT_W-1:0]   i_broad_count,
    input  logic [ltl_pkg::CNT_W-1:0]   i_ir_count,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [ltl_pkg::LUX_W-1:0]   o_lux
);

    localparam int CW = ltl_pkg::CNT_W;
    localparam int QB = ltl_pkg::QUO_W;
    localparam int PW = ltl_pkg::PROD_W;
    localparam int LS = ltl_pkg::LUX_SCALE;
    localparam int LW = ltl_pkg::LUX_W;

    // The whole pipeline moves as one. It halts only when the output register
    // holds a word that the downstream side is not taking; otherwise a new word
    // enters while the previous result is still on display.
    logic w_adv;
    assign w_adv   = !(o_valid && i_stall);
    assign o_stall = !w_adv;

    // ------------------------------------------------------------------
    // Divider: one quotient bit per stage, most significant first. The
    // numerator ir*2^(RATIO_SCALE+1) has only zero bits below ir, so the
    // partial remainder starts as ir and is doubled between stages.
    // The overflow flag marks ir >= 2*broad, whose halved ratio is beyond
    // the last breakpoint; the quotient of such a word is not used.
    // ------------------------------------------------------------------
    logic          r_dvld   [QB];
    logic [CW-1:0] r_dbroad [QB];
    logic [CW-1:0] r_dir    [QB];
    logic [CW-1:0] r_drem   [QB];
    logic [QB-1:0] r_dq     [QB];
    logic          r_dovf   [QB];
    logic          r_dzero  [QB];

    for (genvar k = 0; k < QB; k++) begin : g_div
        logic          n_vld;
        logic [CW-1:0] n_broad;
        logic [CW-1:0] n_ir;
        logic [CW:0]   n_rin;
        logic [QB-1:0] n_qin;
        logic          n_ovf;
        logic          n_zero;
        logic          n_ge;
        logic [CW:0]   n_rsub;

        if (k == 0) begin : g_first
            always_comb begin
                n_vld   = i_valid;
                n_broad = i_broad_count;
                n_ir    = i_ir_count;
                n_rin   = {1'b0, i_ir_count};
                n_qin   = '0;
                n_zero  = (i_broad_count == '0);
                n_ovf   = ({1'b0, i_ir_count} >= {i_broad_count, 1'b0});
            end
        end else begin : g_next
            always_comb begin
                n_vld   = r_dvld[k-1];
                n_broad = r_dbroad[k-1];
                n_ir    = r_dir[k-1];
                n_rin   = {r_drem[k-1], 1'b0};
                n_qin   = r_dq[k-1];
                n_zero  = r_dzero[k-1];
                n_ovf   = r_dovf[k-1];
            end
        end

        always_comb begin
            n_ge   = (n_rin >= {1'b0, n_broad});
            n_rsub = n_rin - {1'b0, n_broad};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dvld[k] <= 1'b0;
            end else if (w_adv) begin
                r_dvld[k] <= n_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_dbroad[k] <= n_broad;
                r_dir[k]    <= n_ir;
                r_drem[k]   <= n_ge ? n_rsub[CW-1:0] : n_rin[CW-1:0];
                r_dq[k]     <= n_qin | (QB'(n_ge) << (QB - 1 - k));
                r_dovf[k]   <= n_ovf;
                r_dzero[k]  <= n_zero;
            end
        end
    end

    // ------------------------------------------------------------------
    // Segment select: a zero broadband count gives a ratio of zero, then
    // the ratio is halved with rounding and looked up in the slope table.
    // An overflowed ratio takes zero slopes, so its lux is zero.
    // ------------------------------------------------------------------
    logic [QB-1:0]      n_ratio;
    logic [QB:0]        n_rinc;
    ltl_pkg::t_coef     n_coef;

    always_comb begin
        n_ratio = r_dzero[QB-1] ? '0 : r_dq[QB-1];
        n_rinc  = {1'b0, n_ratio} + (QB+1)'(1);
        if (r_dovf[QB-1] && !r_dzero[QB-1]) begin
            n_coef = '0;
        end else begin
            n_coef = ltl_pkg::seg_coef(n_rinc[QB:1]);
        end
    end

    logic           r_svld;
    logic [CW-1:0]  r_sbroad;
    logic [CW-1:0]  r_sir;
    ltl_pkg::t_coef r_scoef;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_svld <= 1'b0;
        end else if (w_adv) begin
            r_svld <= r_dvld[QB-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sbroad <= r_dbroad[QB-1];
            r_sir    <= r_dir[QB-1];
            r_scoef  <= n_coef;
        end
    end

    // ------------------------------------------------------------------
    // Products: two 16 by 10 bit multiplications side by side.
    // ------------------------------------------------------------------
    logic [PW-1:0] n_pos;
    logic [PW-1:0] n_neg;

    always_comb begin
        n_pos = PW'(r_sbroad) * PW'(r_scoef.b);
        n_neg = PW'(r_sir) * PW'(r_scoef.m);
    end

    logic          r_mvld;
    logic [PW-1:0] r_mpos;
    logic [PW-1:0] r_mneg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mvld <= 1'b0;
        end else if (w_adv) begin
            r_mvld <= r_svld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_mpos <= n_pos;
            r_mneg <= n_neg;
        end
    end

    // ------------------------------------------------------------------
    // Difference clamped at zero, rounded and scaled down into the
    // output register.
    // ------------------------------------------------------------------
    logic [PW-1:0] n_diff;
    logic [PW:0]   n_sum;

    always_comb begin
        n_diff = (r_mpos > r_mneg) ? (r_mpos - r_mneg) : '0;
        n_sum  = {1'b0, n_diff} + ((PW+1)'(1) << (LS - 1));
    end

    logic          r_ovld;
    logic [LW-1:0] r_olux;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_adv) begin
            r_ovld <= r_mvld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_olux <= n_sum[LS+LW-1:LS];
        end
    end

    assign o_valid = r_ovld;
    assign o_lux   = r_olux;

`ifndef ASSERT_OFF
    // The scaled result never exceeds the brightest slope on a full count.
    a_lux_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_lux <= LW'(ltl_pkg::LUX_MAX)))
        else $error("lux word beyond its range");

    // A word leaving the divider reaches the segment stage on the next edge.
    a_div_to_sel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && r_dvld[QB-1]) |=> r_svld)
        else $error("word lost between divider and segment stage");

    // While the output is held, the later stages keep their words.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> ($stable(r_svld) && $stable(r_mvld) && $stable(r_mpos)))
        else $error("pipeline moved during a stall");
`endif

endmodule
